// ===== design/bcs_pkg.sv =====
package bcs_pkg;

  localparam int unsigned CodeWidth  = 7;
  localparam int unsigned RoundWidth = 4;
  localparam int unsigned OnWidth    = 6;
  localparam int unsigned PhaseWidth = 2;
  localparam int unsigned NumPhases  = 3;

  localparam logic [CodeWidth-1:0]  CodeMax   = 7'd99;
  localparam logic [PhaseWidth-1:0] LastPhase = 2'd2;

  // Multiplying by 205 and dropping 11 bits divides by ten for every code up to 99.
  localparam logic [7:0] DivTenMult  = 8'd205;
  localparam int unsigned DivTenShift = 11;
  localparam logic [3:0] RoundDiv    = 4'd10;
  localparam logic [2:0] OnMult      = 3'd5;

  typedef struct packed {
    logic [NumPhases-1:0] drive;
    logic                 active;
    logic                 done;
  } bcs_result_t;

  function automatic logic [RoundWidth-1:0] round_of(input logic [CodeWidth-1:0] code);
    logic [14:0] prod;
    prod = 15'(code) * 15'(DivTenMult);
    return prod[DivTenShift +: RoundWidth];
  endfunction

  function automatic logic [OnWidth-1:0] on_time_of(input logic [CodeWidth-1:0] code);
    logic [RoundWidth-1:0] quot;
    logic [CodeWidth-1:0]  rem;
    quot = round_of(code);
    rem  = code - CodeWidth'(quot) * CodeWidth'(RoundDiv);
    return OnWidth'(rem[3:0]) * OnWidth'(OnMult);
  endfunction

endpackage

// ===== design/bcs_seq_core.sv =====
module bcs_seq_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  step_i,
  input  logic                                  run_enable_i,
  input  logic                                  pwm_ready_i,
  input  logic [bcs_pkg::CodeWidth-1:0]         code_i,
  output bcs_pkg::bcs_result_t                  result_o
);

  localparam logic [1:0] SeqIdle   = 2'd0;
  localparam logic [1:0] SeqRun    = 2'd1;
  localparam logic [1:0] SeqFinish = 2'd2;

  logic [1:0]                         state_q, state_d;
  logic [bcs_pkg::PhaseWidth-1:0]     phase_q, phase_d;
  logic [bcs_pkg::OnWidth-1:0]        on_cnt_q, on_cnt_d;
  logic [bcs_pkg::OnWidth-1:0]        on_lim_q, on_lim_d;
  logic [bcs_pkg::RoundWidth-1:0]     round_q, round_d;
  logic [bcs_pkg::RoundWidth-1:0]     round_lim_q, round_lim_d;
  logic                               done_q, done_d;
  logic [bcs_pkg::NumPhases-1:0]      drive_q, drive_d;
  logic                               run_phase;
  logic                               active;
  logic [bcs_pkg::RoundWidth-1:0]     round_next;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    on_cnt_d    = on_cnt_q;
    on_lim_d    = on_lim_q;
    round_d     = round_q;
    round_lim_d = round_lim_q;
    done_d      = done_q;
    drive_d     = drive_q;
    run_phase   = 1'b0;
    active      = 1'b0;
    round_next  = round_q + 1'b1;

    if (!run_enable_i) begin
      done_d = 1'b0;
    end else if (done_q) begin
      state_d = SeqIdle;
    end else begin
      case (state_q)
        SeqRun: begin
          if (on_cnt_q >= on_lim_q) begin
            on_cnt_d = bcs_pkg::OnWidth'(1);
            if (phase_q >= bcs_pkg::LastPhase) begin
              phase_d = '0;
              round_d = round_next;
              if (round_next >= round_lim_q) begin
                state_d = SeqFinish;
              end else begin
                run_phase = 1'b1;
              end
            end else begin
              phase_d   = phase_q + 1'b1;
              run_phase = 1'b1;
            end
          end else begin
            on_cnt_d  = on_cnt_q + 1'b1;
            run_phase = 1'b1;
          end
        end
        SeqFinish: begin
          done_d = 1'b1;
        end
        default: begin
          if (pwm_ready_i) begin
            round_lim_d = bcs_pkg::round_of(code_i);
            on_lim_d    = bcs_pkg::on_time_of(code_i);
            round_d     = '0;
            on_cnt_d    = '0;
            phase_d     = '0;
            done_d      = 1'b0;
            state_d     = SeqRun;
          end
        end
      endcase
    end

    if (run_phase && (on_lim_d != '0) && (phase_d <= bcs_pkg::LastPhase)) begin
      drive_d = bcs_pkg::NumPhases'(1) << phase_d;
      active  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SeqIdle;
      phase_q     <= '0;
      on_cnt_q    <= '0;
      on_lim_q    <= '0;
      round_q     <= '0;
      round_lim_q <= '0;
      done_q      <= 1'b0;
      drive_q     <= '0;
    end else if (step_i) begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      on_cnt_q    <= on_cnt_d;
      on_lim_q    <= on_lim_d;
      round_q     <= round_d;
      round_lim_q <= round_lim_d;
      done_q      <= done_d;
      drive_q     <= drive_d;
    end
  end

  assign result_o.drive  = drive_d;
  assign result_o.active = active;
  assign result_o.done   = done_d;

endmodule

// ===== design/bootstrap_charge_sequencer.sv =====
// Bootstrap capacitor precharge sequencer, advanced by one control tick per input transfer.
// The input channel (in_valid_i/in_ready_o) carries run_enable_i and pwm_ready_i for one tick.
// Every accepted tick produces exactly one result transfer on the output channel
// (out_valid_o/out_ready_i) with the phase selects, drive_active_o and done_res_o.
// The result appears in the output register in the cycle after the tick is accepted.
// A new tick can be accepted every cycle unless the receiver stalls, including the cycle in
// which the held result is taken; one tick per cycle, set by the single output register.
// If the receiver stalls, the output register holds its result and in_ready_o drops
// until that result is taken, so the sequencer state never runs ahead of its outputs.
// The configuration channel (cfg_valid_i/bootstrap_code_i) is always ready; codes above 99
// are saturated to 99. The code is sampled when a sequence starts.
// Reset clears the code, the sequencer to idle with all phases off, and the output register.
module bootstrap_charge_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bcs_pkg::CodeWidth-1:0] bootstrap_code_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          run_enable_i,
  input  logic                          pwm_ready_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          drive_x_o,
  output logic                          drive_y_o,
  output logic                          drive_z_o,
  output logic                          drive_active_o,
  output logic                          done_res_o
);

  logic [bcs_pkg::CodeWidth-1:0] code_q;
  logic                          out_valid_q;
  bcs_pkg::bcs_result_t          res_q;
  bcs_pkg::bcs_result_t          step_res;
  logic                          step;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign step        = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q <= '0;
    end else if (cfg_valid_i) begin
      code_q <= (bootstrap_code_i > bcs_pkg::CodeMax) ? bcs_pkg::CodeMax : bootstrap_code_i;
    end
  end

  bcs_seq_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .run_enable_i (run_enable_i),
    .pwm_ready_i  (pwm_ready_i),
    .code_i       (code_q),
    .result_o     (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (step) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_x_o      = res_q.drive[0];
  assign drive_y_o      = res_q.drive[1];
  assign drive_z_o      = res_q.drive[2];
  assign drive_active_o = res_q.active;
  assign done_res_o     = res_q.done;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("Input accepted while a result is stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && drive_active_o |-> $onehot({drive_z_o, drive_y_o, drive_x_o}))
    else $error("Active drive without exactly one phase selected.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(done_res_o && drive_active_o))
    else $error("Phase driven while charging is reported done.");

endmodule

// ===== tb/tb_bootstrap_charge_sequencer.sv =====
module tb_bootstrap_charge_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned NumPhasesRun = 9;

  typedef enum logic [1:0] {
    SEQ_IDLE   = 2'd0,
    SEQ_RUN    = 2'd1,
    SEQ_FINISH = 2'd2
  } seq_state_e;

  class charge_scoreboard;
    logic [bcs_pkg::CodeWidth-1:0]  code_reg;
    seq_state_e                     seq_st;
    logic [bcs_pkg::PhaseWidth-1:0] phase_sel;
    logic [bcs_pkg::OnWidth-1:0]    on_ticks;
    logic [bcs_pkg::OnWidth-1:0]    on_goal;
    logic [bcs_pkg::RoundWidth-1:0] round_cnt;
    logic [bcs_pkg::RoundWidth-1:0] round_goal;
    logic                           done_q;
    logic [bcs_pkg::NumPhases-1:0]  switch_sel;
    bcs_pkg::bcs_result_t           expected_q[$];
    int unsigned                    errors;
    int unsigned                    ticks;
    int unsigned                    checked;
    int unsigned                    driven_ticks;
    int unsigned                    done_results;

    function new();
      code_reg   = '0;
      seq_st     = SEQ_IDLE;
      phase_sel  = '0;
      on_ticks   = '0;
      on_goal    = '0;
      round_cnt  = '0;
      round_goal = '0;
      done_q     = 1'b0;
      switch_sel = '0;
    endfunction

    function void set_code(logic [bcs_pkg::CodeWidth-1:0] value);
      code_reg = (value > bcs_pkg::CodeMax) ? bcs_pkg::CodeMax : value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_tick(logic run_en, logic pwm_rdy);
      logic                 drive_now;
      logic                 active;
      bcs_pkg::bcs_result_t exp_res;
      drive_now = 1'b0;
      active    = 1'b0;
      ticks++;
      if (!run_en) begin
        done_q = 1'b0;
      end else if (done_q) begin
        seq_st = SEQ_IDLE;
      end else begin
        case (seq_st)
          SEQ_RUN: begin
            if (on_ticks >= on_goal) begin
              on_ticks = 1;
              if (phase_sel >= bcs_pkg::LastPhase) begin
                phase_sel = '0;
                round_cnt = round_cnt + 1'b1;
                if (round_cnt >= round_goal) begin
                  seq_st = SEQ_FINISH;
                end else begin
                  drive_now = 1'b1;
                end
              end else begin
                phase_sel = phase_sel + 1'b1;
                drive_now = 1'b1;
              end
            end else begin
              on_ticks  = on_ticks + 1'b1;
              drive_now = 1'b1;
            end
          end
          SEQ_FINISH: begin
            done_q = 1'b1;
          end
          default: begin
            if (pwm_rdy) begin
              round_goal = bcs_pkg::RoundWidth'(code_reg / 10);
              round_cnt  = '0;
              on_goal    = bcs_pkg::OnWidth'((code_reg % 10) * 5);
              on_ticks   = '0;
              phase_sel  = '0;
              done_q     = 1'b0;
              seq_st     = SEQ_RUN;
            end
          end
        endcase
      end
      if (drive_now && on_goal != 0 && phase_sel <= bcs_pkg::LastPhase) begin
        switch_sel = 3'b001 << phase_sel;
        active     = 1'b1;
        driven_ticks++;
      end
      exp_res.drive  = switch_sel;
      exp_res.active = active;
      exp_res.done   = done_q;
      expected_q.push_back(exp_res);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [bcs_pkg::NumPhases-1:0] drive, logic active, logic done);
      bcs_pkg::bcs_result_t exp_res;
      string                phase_names[bcs_pkg::NumPhases];
      phase_names = '{"drive_x", "drive_y", "drive_z"};
      if (expected_q.size() == 0) begin
        report($sformatf("result drive=%b active=%b done=%b with nothing expected",
                         drive, active, done));
      end else begin
        exp_res = expected_q.pop_front();
        checked++;
        if (done) done_results++;
        for (int i = 0; i < bcs_pkg::NumPhases; i++) begin
          if (drive[i] !== exp_res.drive[i]) begin
            report($sformatf("result %0d: %s got %b expected %b", checked,
                             phase_names[i], drive[i], exp_res.drive[i]));
          end
        end
        if (active !== exp_res.active) begin
          report($sformatf("result %0d: drive_active got %b expected %b", checked,
                           active, exp_res.active));
        end
        if (done !== exp_res.done) begin
          report($sformatf("result %0d: done_res got %b expected %b", checked,
                           done, exp_res.done));
        end
      end
    endtask
  endclass

  logic                          clk_i            = 1'b0;
  logic                          rst_ni           = 1'b0;
  logic                          cfg_valid_i      = 1'b0;
  logic                          cfg_ready_o;
  logic [bcs_pkg::CodeWidth-1:0] bootstrap_code_i = '0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_ready_o;
  logic                          run_enable_i     = 1'b0;
  logic                          pwm_ready_i      = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i      = 1'b0;
  logic                          drive_x_o;
  logic                          drive_y_o;
  logic                          drive_z_o;
  logic                          drive_active_o;
  logic                          done_res_o;

  charge_scoreboard sb = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req      = 1'b0;
  int unsigned quiet_cycles  = 0;
  int unsigned codes_written = 0;

  bootstrap_charge_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .bootstrap_code_i(bootstrap_code_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .run_enable_i    (run_enable_i),
    .pwm_ready_i     (pwm_ready_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .drive_x_o       (drive_x_o),
    .drive_y_o       (drive_y_o),
    .drive_z_o       (drive_z_o),
    .drive_active_o  (drive_active_o),
    .done_res_o      (done_res_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_tick(run_enable_i, pwm_ready_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_result({drive_z_o, drive_y_o, drive_x_o}, drive_active_o, done_res_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= StallLimit) begin
          $display("Timeout after %0d cycles without a transfer", quiet_cycles);
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // The receiver normally stalls at random; on request it holds off for a long stretch.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_tick(input logic run_en, input logic pwm_rdy);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    run_enable_i <= run_en;
    pwm_ready_i  <= pwm_rdy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_code(input logic [bcs_pkg::CodeWidth-1:0] code);
    cfg_valid_i      <= 1'b1;
    bootstrap_code_i <= code;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_code(code);
    codes_written++;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned                   sent;
    int unsigned                   phase_items;
    logic [bcs_pkg::CodeWidth-1:0] phase_code;
    logic [bcs_pkg::CodeWidth-1:0] code_list[NumPhasesRun];
    sent      = 0;
    code_list = '{7'd0, 7'd19, 7'd23, 7'd5, 7'd31, 7'd12, 7'd40, 7'd0, 7'd127};
    code_list[7] = bcs_pkg::CodeWidth'($urandom_range(0, 39));
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 36;
    recv_idle_pct = 73;

    // Zero rounds and zero on time, done, then a stop that clears done.
    write_code(7'd0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    repeat (5) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    drain_results();

    // One round of five ticks per phase, frozen once by a stop.
    write_code(7'd11);
    send_tick(1'b1, 1'b1);
    repeat (4) send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    repeat (8) send_tick(1'b1, 1'b1);
    drain_results();

    for (int p = 0; p < NumPhasesRun; p++) begin
      phase_code  = code_list[p];
      phase_items = (p == NumPhasesRun - 1) ? 270 : 110;
      write_code(phase_code);
      for (int i = 0; i < phase_items; i++) begin
        if (sent < 380) begin
          send_idle_pct = 36;
          recv_idle_pct = 73;
        end else if (sent < 760) begin
          send_idle_pct = 73;
          recv_idle_pct = 36;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (sent == 800) hold_req = 1'b1;
        send_tick($urandom_range(0, 99) >= 8, $urandom_range(0, 99) < 25);
        sent++;
      end
      drain_results();
    end

    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending()));
    end
    $display("Run covered %0d ticks and %0d checked results over %0d code writes.",
             sb.ticks, sb.checked, codes_written);
    $display("Ticks that drove a phase: %0d; results with done set: %0d; mismatches: %0d.",
             sb.driven_ticks, sb.done_results, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
